@@ sv/differential_drive_odometry_assert.svh @@
// Assertion macros for the differential drive odometry block.
// Used by the top level; ASSERT_OFF turns every check into nothing.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`ifndef ASSERT_OFF
// Concurrent check on an explicit clock and active-low reset
`define DDO_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Concurrent check on the block clock and reset
`define DDO_ASSERT(name, prop, msg) `DDO_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)
`else
`define DDO_ASSERT_CLK(name, clk, rst_n, prop, msg)
`define DDO_ASSERT(name, prop, msg)
`endif
`endif

@@ sv/ddo_pkg.sv @@
// Shared types, constants and the arctangent table of the odometry block.
// No dependencies; used by ddo_cordic and differential_drive_odometry.
`default_nettype none

package ddo_pkg;

  // Parameter defaults
  localparam int unsigned POSITION_BITS_DEF     = 32;
  localparam int unsigned ANGLE_BITS_DEF        = 32;
  localparam int unsigned CORDIC_ITERATIONS_DEF = 24;

  // Fixed formats
  localparam int unsigned GUARD_BITS  = 8;
  localparam int unsigned DIST_W      = 20;
  localparam int unsigned INV_W       = 24;
  localparam int unsigned ANG_W       = 32;
  localparam int unsigned OUT_W       = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 184;

  localparam logic [INV_W-1:0] INV_AXIS_RESET = 24'd468114;
  // round(2^32 / (2 pi)) and CORDIC gain compensation, both Q0.32
  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [31:0] GAIN_Q32       = 32'd2608131496;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_LOAD,
    ST_LO,
    ST_HI,
    ST_SUM,
    ST_ROT,
    ST_POST,
    ST_HSET,
    ST_CLEAR
  } ddo_state_e;

  // What the current scaling pass works on
  typedef enum logic [1:0] {
    PH_TURN,
    PH_DISP,
    PH_HOME_X,
    PH_HOME_Y
  } ddo_phase_e;

  // atan(2^-i), 2^32 per turn
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41721;
      5'd15: a = 32'd20860;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2607;
      5'd19: a = 32'd1303;
      5'd20: a = 32'd651;
      5'd21: a = 32'd325;
      5'd22: a = 32'd162;
      5'd23: a = 32'd81;
      5'd24: a = 32'd40;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd2;
      5'd29: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ sv/ddo_cordic.sv @@
// Iterative rotation-mode CORDIC: one micro-rotation per clock.
// Depends on ddo_pkg (arctangent table).
`default_nettype none

module ddo_cordic #(
  parameter int unsigned WIDTH      = 43,
  parameter int unsigned ITERATIONS = ddo_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire logic signed [WIDTH-1:0] x_i,
  input  wire logic signed [WIDTH-1:0] y_i,
  input  wire logic [31:0]        angle_i,
  output logic                    done_o,
  output logic signed [WIDTH-1:0] x_o,
  output logic signed [WIDTH-1:0] y_o
);

  localparam int unsigned CNTW = $clog2(ITERATIONS);
  localparam logic [CNTW-1:0] LAST = CNTW'(ITERATIONS - 1);

  logic                    busy_q;
  logic                    done_q;
  logic [CNTW-1:0]         cnt_q;
  logic signed [WIDTH-1:0] x_q, y_q;
  logic signed [32:0]      z_q;

  // Fold the angle into [-quarter, quarter) by negating the vector
  logic [31:0]             quad;
  logic                    flip;
  logic [31:0]             ang_f;
  logic signed [WIDTH-1:0] x_in, y_in;

  assign quad  = angle_i + 32'h4000_0000;
  assign flip  = quad[31];
  assign ang_f = {angle_i[31] ^ flip, angle_i[30:0]};
  assign x_in  = flip ? -x_i : x_i;
  assign y_in  = flip ? -y_i : y_i;

  // One micro-rotation
  logic [4:0]              sh;
  logic signed [WIDTH-1:0] dx, dy;
  logic signed [32:0]      at;

  assign sh = 5'(cnt_q);
  assign dx = y_q >>> sh;
  assign dy = x_q >>> sh;
  assign at = $signed({1'b0, ddo_pkg::atan_lut(sh)});

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + CNTW'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_in;
      y_q <= y_in;
      z_q <= 33'($signed(ang_f));
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

`default_nettype wire

@@ sv/differential_drive_odometry.sv @@
// Channel   Dir  Contents (low bit first)
// s_axis    in   tdata: left_distance[19:0], right_distance[39:20]; tuser: clear_pose
// m_axis    out  tdata: position_x, position_y, heading_angle, travel, home_x,
//                home_y, 4 zero bits; tuser: saturated
// cfg       in   cfg_wdata_i = inverse_axis_length, written when cfg_we_i is high
//
// For a motion word, the CORDIC unit runs two rotations and the one 32x32 multiplier
// makes nine products in turn. s_axis_tready_o is high only while the sequencer
// is idle. A finished word waits in the output register; the next word is accepted
// meanwhile and holds its last step until that register frees. Reset clears pose
// and heading and restores inverse_axis_length to its default.
// Depends on ddo_pkg, ddo_cordic and differential_drive_odometry_assert.svh.
`default_nettype none

`include "differential_drive_odometry_assert.svh"

module differential_drive_odometry #(
  parameter int unsigned POSITION_BITS     = ddo_pkg::POSITION_BITS_DEF,
  parameter int unsigned ANGLE_BITS        = ddo_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_ITERATIONS = ddo_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // input stream
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire [ddo_pkg::IN_TDATA_W-1:0]        s_axis_tdata_i,  // left, right
  input  wire                                  s_axis_tuser_i,  // clear_pose
  // output stream
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  output logic [ddo_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,  // px, py, hdg, travel, hx, hy
  output logic                                 m_axis_tuser_o,  // saturated
  // configuration
  input  wire                                  cfg_we_i,
  input  wire [ddo_pkg::INV_W-1:0]             cfg_wdata_i
);

  localparam int unsigned P    = POSITION_BITS;
  localparam int unsigned MAXP = (P > 21) ? P : 21;
  localparam int unsigned CW   = MAXP + ddo_pkg::GUARD_BITS + 3;   // CORDIC width
  localparam int unsigned MAGW = (P > 45) ? P : 45;                // scaler magnitude
  localparam int unsigned RW   = CW - ddo_pkg::GUARD_BITS;          // home result
  localparam int unsigned DW   = RW - 1;                            // displacement
  localparam int unsigned SW   = RW;                                // pose + step
  localparam int unsigned CLW  = (RW + 1 > 33) ? RW + 1 : 33;       // clip width
  localparam int unsigned LOWB = 32 - ANGLE_BITS;

  localparam logic [32:0] UNIT = 33'd1 << LOWB;
  localparam logic [32:0] HALF = UNIT >> 1;
  localparam logic [32:0] MASK = ~(UNIT - 33'd1);

  localparam logic signed [CW-1:0] RND8 = CW'(128);
  localparam logic signed [CW-1:0] RND9 = CW'(256);

  localparam logic signed [CLW-1:0] PHI = {{(CLW - P + 1){1'b0}}, {(P - 1){1'b1}}};
  localparam logic signed [CLW-1:0] PLO = ~PHI;
  localparam logic signed [CLW-1:0] OHI = {{(CLW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [CLW-1:0] OLO = ~OHI;

  function automatic logic signed [CLW-1:0] clip(input logic signed [CLW-1:0] v,
                                                 input logic signed [CLW-1:0] lo,
                                                 input logic signed [CLW-1:0] hi);
    logic signed [CLW-1:0] r;
    r = v;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  ddo_pkg::ddo_state_e state_q, state_d;
  ddo_pkg::ddo_phase_e phase_q;

  logic [ddo_pkg::INV_W-1:0]         inv_q;
  logic signed [ddo_pkg::DIST_W-1:0] left_q, right_q;
  logic signed [P-1:0]               pose_x_q, pose_y_q;
  logic [31:0]                       heading_q;
  logic [31:0]                       mid_q;
  logic [MAGW-1:0]                   mag_q;
  logic                              neg_q;
  logic [63:0]                       mul_q;
  logic [31:0]                       carry_q;
  logic signed [CW-1:0]              vx_q;
  logic                              sat_q;
  logic                              out_valid_q;
  logic [ddo_pkg::OUT_TDATA_W-1:0]   out_data_q;
  logic                              out_sat_q;

  // ---------------------------------------------------------------------------
  // Wheel sums
  logic signed [20:0] sum, diff;
  logic [20:0]        sum_mag, diff_mag;

  assign sum      = 21'(left_q) + 21'(right_q);
  assign diff     = 21'(left_q) - 21'(right_q);
  assign sum_mag  = sum[20] ? 21'(-sum) : 21'(sum);
  assign diff_mag = diff[20] ? 21'(-diff) : 21'(diff);

  // Pose magnitudes for the home vector
  logic [P-1:0] pmag_x, pmag_y;
  assign pmag_x = pose_x_q[P-1] ? P'(-pose_x_q) : P'(pose_x_q);
  assign pmag_y = pose_y_q[P-1] ? P'(-pose_y_q) : P'(pose_y_q);

  // ---------------------------------------------------------------------------
  // Rounded scaling result: hi product plus rounded carry of the lo product
  logic [63:0]          lo_round;
  logic [MAGW-1:0]      res;
  logic [CW-1:0]        sc_mag;
  logic signed [CW-1:0] sc_vec, sc_shift;

  assign lo_round = mul_q + 64'h8000_0000;
  assign res      = mul_q[MAGW-1:0] + MAGW'(carry_q);
  assign sc_mag   = CW'(res[MAXP-1:0]);
  assign sc_vec   = neg_q ? -$signed(sc_mag) : $signed(sc_mag);
  assign sc_shift = sc_vec <<< ddo_pkg::GUARD_BITS;

  // Heading change, snapped to the angle resolution
  logic [32:0] d_mag, d_val, dq;
  logic [31:0] mid_d;

  assign d_mag = res[32:0];
  assign d_val = neg_q ? -d_mag : d_mag;
  assign dq    = (d_val + HALF) & MASK;
  assign mid_d = heading_q + dq[32:1];

  // ---------------------------------------------------------------------------
  // CORDIC unit
  logic                 cordic_start;
  logic signed [CW-1:0] cordic_x0, cordic_y0;
  logic [31:0]          cordic_ang;
  logic                 cordic_done;
  logic signed [CW-1:0] cx, cy;

  ddo_cordic #(
    .WIDTH      (CW),
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .x_i     (cordic_x0),
    .y_i     (cordic_y0),
    .angle_i (cordic_ang),
    .done_o  (cordic_done),
    .x_o     (cx),
    .y_o     (cy)
  );

  // Displacement: round with one extra shift, which halves (L+R)
  logic signed [CW-1:0]  dx_full, dy_full;
  logic signed [SW-1:0]  psum_x, psum_y;
  logic signed [CLW-1:0] pclip_x, pclip_y;
  logic                  pflag;

  assign dx_full = (cx + RND9) >>> (ddo_pkg::GUARD_BITS + 1);
  assign dy_full = (cy + RND9) >>> (ddo_pkg::GUARD_BITS + 1);
  assign psum_x  = SW'(pose_x_q) + SW'($signed(dx_full[DW-1:0]));
  assign psum_y  = SW'(pose_y_q) + SW'($signed(dy_full[DW-1:0]));
  assign pclip_x = clip(CLW'(psum_x), PLO, PHI);
  assign pclip_y = clip(CLW'(psum_y), PLO, PHI);
  assign pflag   = (pclip_x != CLW'(psum_x)) || (pclip_y != CLW'(psum_y));

  // Home vector and output clipping
  logic signed [CW-1:0]  hx_full, hy_full;
  logic signed [RW:0]    hy_neg;
  logic signed [CLW-1:0] oc_px, oc_py, oc_hx, oc_hy;
  logic                  oflag;

  assign hx_full = (cx + RND8) >>> ddo_pkg::GUARD_BITS;
  assign hy_full = (cy + RND8) >>> ddo_pkg::GUARD_BITS;
  assign hy_neg  = -(RW + 1)'($signed(hy_full[RW-1:0]));
  assign oc_px   = clip(CLW'(pose_x_q), OLO, OHI);
  assign oc_py   = clip(CLW'(pose_y_q), OLO, OHI);
  assign oc_hx   = clip(CLW'($signed(hx_full[RW-1:0])), OLO, OHI);
  assign oc_hy   = clip(CLW'(hy_neg), OLO, OHI);
  assign oflag   = (oc_px != CLW'(pose_x_q)) || (oc_py != CLW'(pose_y_q)) ||
                   (oc_hx != CLW'($signed(hx_full[RW-1:0]))) || (oc_hy != CLW'(hy_neg));

  logic [ddo_pkg::OUT_TDATA_W-1:0] result_word;
  assign result_word = {4'b0, oc_hy[31:0], oc_hx[31:0], sum[20:1], heading_q,
                        oc_py[31:0], oc_px[31:0]};

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  logic out_free;
  logic in_accept;

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ddo_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = s_axis_tuser_i ? ddo_pkg::ST_CLEAR : ddo_pkg::ST_PROD;
        end
      end
      ddo_pkg::ST_PROD: state_d = ddo_pkg::ST_LOAD;
      ddo_pkg::ST_LOAD: state_d = ddo_pkg::ST_LO;
      ddo_pkg::ST_LO:   state_d = ddo_pkg::ST_HI;
      ddo_pkg::ST_HI:   state_d = ddo_pkg::ST_SUM;
      ddo_pkg::ST_SUM: begin
        if (phase_q == ddo_pkg::PH_DISP || phase_q == ddo_pkg::PH_HOME_Y) begin
          state_d = ddo_pkg::ST_ROT;
        end else begin
          state_d = ddo_pkg::ST_LO;
        end
      end
      ddo_pkg::ST_ROT: begin
        if (cordic_done) begin
          state_d = ddo_pkg::ST_POST;
        end
      end
      ddo_pkg::ST_POST: begin
        if (phase_q == ddo_pkg::PH_DISP) begin
          state_d = ddo_pkg::ST_HSET;
        end else if (out_free) begin
          state_d = ddo_pkg::ST_IDLE;
        end
      end
      ddo_pkg::ST_HSET: state_d = ddo_pkg::ST_LO;
      ddo_pkg::ST_CLEAR: begin
        if (out_free) begin
          state_d = ddo_pkg::ST_IDLE;
        end
      end
      default: state_d = ddo_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  logic [31:0] mul_a, mul_b;
  logic [31:0] kconst;
  logic        out_load;
  logic        out_clear;

  assign kconst = (phase_q == ddo_pkg::PH_TURN) ? ddo_pkg::INV_TWO_PI_Q32 : ddo_pkg::GAIN_Q32;

  always_comb begin
    s_axis_tready_o = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    cordic_start    = 1'b0;
    cordic_x0       = sc_shift;
    cordic_y0       = '0;
    cordic_ang      = mid_q;
    out_load        = 1'b0;
    out_clear       = 1'b0;
    case (state_q)
      ddo_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      ddo_pkg::ST_PROD: begin
        mul_a = 32'(diff_mag);
        mul_b = 32'(inv_q);
      end
      ddo_pkg::ST_LO: begin
        mul_a = mag_q[31:0];
        mul_b = kconst;
      end
      ddo_pkg::ST_HI: begin
        mul_a = 32'(mag_q[MAGW-1:32]);
        mul_b = kconst;
      end
      ddo_pkg::ST_SUM: begin
        if (phase_q == ddo_pkg::PH_DISP) begin
          cordic_start = 1'b1;
        end else if (phase_q == ddo_pkg::PH_HOME_Y) begin
          cordic_start = 1'b1;
          cordic_x0    = vx_q;
          cordic_y0    = sc_shift;
          cordic_ang   = 32'd0 - heading_q;
        end
      end
      ddo_pkg::ST_POST: begin
        out_load = (phase_q == ddo_pkg::PH_HOME_Y) && out_free;
      end
      ddo_pkg::ST_CLEAR: begin
        out_load  = out_free;
        out_clear = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state, pose and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddo_pkg::ST_IDLE;
      inv_q       <= ddo_pkg::INV_AXIS_RESET;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      heading_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        inv_q <= cfg_wdata_i;
      end
      // clear request zeroes the pose at accept
      if (in_accept && s_axis_tuser_i) begin
        pose_x_q  <= '0;
        pose_y_q  <= '0;
        heading_q <= '0;
      end
      if (state_q == ddo_pkg::ST_SUM && phase_q == ddo_pkg::PH_TURN) begin
        heading_q <= heading_q + dq[31:0];
      end
      if (state_q == ddo_pkg::ST_POST && phase_q == ddo_pkg::PH_DISP) begin
        pose_x_q <= pclip_x[P-1:0];
        pose_y_q <= pclip_y[P-1:0];
      end
      // output word handshake
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (in_accept) begin
      left_q  <= $signed(s_axis_tdata_i[19:0]);
      right_q <= $signed(s_axis_tdata_i[39:20]);
      sat_q   <= 1'b0;
    end
    case (state_q)
      ddo_pkg::ST_LOAD: begin
        mag_q   <= mul_q[MAGW-1:0];
        neg_q   <= diff[20];
        phase_q <= ddo_pkg::PH_TURN;
      end
      ddo_pkg::ST_HI: begin
        carry_q <= lo_round[63:32];
      end
      ddo_pkg::ST_SUM: begin
        if (phase_q == ddo_pkg::PH_TURN) begin
          mid_q   <= mid_d;
          mag_q   <= MAGW'(sum_mag);
          neg_q   <= sum[20];
          phase_q <= ddo_pkg::PH_DISP;
        end else if (phase_q == ddo_pkg::PH_HOME_X) begin
          vx_q    <= sc_shift;
          mag_q   <= MAGW'(pmag_y);
          neg_q   <= !pose_y_q[P-1] && (pose_y_q != '0);
          phase_q <= ddo_pkg::PH_HOME_Y;
        end
      end
      ddo_pkg::ST_POST: begin
        if (phase_q == ddo_pkg::PH_DISP) begin
          sat_q <= sat_q | pflag;
        end
      end
      ddo_pkg::ST_HSET: begin
        mag_q   <= MAGW'(pmag_x);
        neg_q   <= !pose_x_q[P-1] && (pose_x_q != '0);
        phase_q <= ddo_pkg::PH_HOME_X;
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_q <= out_clear ? '0 : result_word;
      out_sat_q  <= out_clear ? 1'b0 : (sat_q | oflag);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sat_q;

  // ---------------------------------------------------------------------------
  // Checks
  `DDO_ASSERT(a_busy_after_accept, in_accept |=> !s_axis_tready_o, "ready high right after accept")
  `DDO_ASSERT(a_done_in_rot, cordic_done |-> (state_q == ddo_pkg::ST_ROT), "CORDIC done outside rotation wait")
  `DDO_ASSERT(a_clear_zeroes_pose, (in_accept && s_axis_tuser_i) |=> (pose_x_q == '0 && pose_y_q == '0 && heading_q == '0), "clear did not zero pose")

endmodule

`default_nettype wire
